// ===== hw/rtl/brbp_pkg.sv =====
// ---------------------------------------------------------------------------
// brbp_pkg: shared types and constants of the byte ring buffer with peek
// Store depth, position and count widths, operation codes, item structs.
// ---------------------------------------------------------------------------
`default_nettype none

package brbp_pkg;

  localparam int DEPTH  = 1024;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int BYTE_W = 8;
  localparam int FUNC_W = 2;
  localparam int STEP_W = $clog2(ADDR_W);

  localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_POP   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_PEEK  = 2'd2;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [BYTE_W-1:0] byte_in;
    logic              use_head;
    logic [ADDR_W-1:0] peek_pos;
    logic              last_byte;
  } req_t;

  typedef struct packed {
    logic [BYTE_W-1:0] byte_out;
    logic              ok;
    logic [CNT_W-1:0]  fill_level;
    logic [CNT_W-1:0]  free_space;
    logic [ADDR_W-1:0] next_peek_pos;
    logic              last_out;
  } rsp_t;

endpackage

`default_nettype wire

// ===== hw/rtl/brbp_ram.sv =====
// ---------------------------------------------------------------------------
// brbp_ram: generic single-write, single-read RAM
// One write port, one read port, read data registered.
// ---------------------------------------------------------------------------
`default_nettype none

module brbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/brbp_mod.sv =====
// ---------------------------------------------------------------------------
// brbp_mod: bit-serial remainder unit
// Restoring remainder of a position by the capacity, one bit per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module brbp_mod
  import brbp_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [ADDR_W-1:0] dividend,
  input  wire logic [CNT_W-1:0]  divisor,
  output logic                   done,
  output logic      [ADDR_W-1:0] rem
);

  logic              busy;
  logic [ADDR_W-1:0] shift;
  logic [STEP_W-1:0] step;
  logic [CNT_W-1:0]  trial;
  logic [ADDR_W-1:0] rem_next;

  // shift in the next dividend bit, subtract once if it fits
  always_comb begin
    trial    = {rem, shift[ADDR_W-1]};
    rem_next = (trial >= divisor) ? ADDR_W'(trial - divisor) : trial[ADDR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        rem   <= '0;
        shift <= dividend;
        step  <= '0;
      end else if (busy) begin
        rem   <= rem_next;
        shift <= {shift[ADDR_W-2:0], 1'b0};
        step  <= step + STEP_W'(1);
        if (step == STEP_W'(ADDR_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  a_start_idle: assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("remainder unit started while busy");
  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (CNT_W'(rem) < divisor))
    else $error("remainder not below divisor");
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("done without a running division");

endmodule

`default_nettype wire

// ===== hw/rtl/byte_ring_buffer_with_peek_unit.sv =====
// ---------------------------------------------------------------------------
// byte_ring_buffer_with_peek_unit: circular byte FIFO with peek
// Byte store in a registered-read RAM; write appends, pop removes, peek reads
// at head or at a given position and returns the next one, wrapped at capacity.
// ---------------------------------------------------------------------------
//
//  channel | signals                     | direction | carries
//  --------+-----------------------------+-----------+-----------------------
//  req     | req_valid, req_stall, req   | in        | one byte operation
//  rsp     | rsp_valid, rsp_stall, rsp   | out       | one result per item
//  cfg     | cfg_valid, cfg_ready, cfg_data | in     | capacity in use
//
//  Flow: a write or a refused item goes straight to the finish state, a pop
//  or a peek also passes the read-data state for the registered RAM read.
//  A peek at a position at or above the capacity first runs the bit-serial
//  remainder unit. One item is in flight at a time.
//  Reset: synchronous; empties the FIFO and sets the capacity to the full
//  depth. Stored bytes are not cleared.
//  Stalls: the result register holds an item while rsp_stall is high; the
//  unit finishes the next item and then waits for that register to drain.
//  A capacity write empties the FIFO (head, tail and fill back to zero).
// ---------------------------------------------------------------------------
`default_nettype none

module byte_ring_buffer_with_peek_unit
  import brbp_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             req_valid,
  output logic                  req_stall,
  input  wire req_t             req,
  output logic                  rsp_valid,
  input  wire logic             rsp_stall,
  output rsp_t                  rsp,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [CNT_W-1:0] cfg_data
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_MOD,
    S_RDATA,
    S_FIN
  } state_t;

  state_t            state;
  logic [ADDR_W-1:0] head;
  logic [ADDR_W-1:0] tail;
  logic [CNT_W-1:0]  fill;
  logic [CNT_W-1:0]  capacity;

  // result under construction for the item in flight
  logic [BYTE_W-1:0] res_byte;
  logic              res_ok;
  logic [ADDR_W-1:0] res_npp;
  logic              res_last;

  logic              full;
  logic              empty;
  logic              accept;
  logic              ppos_in_range;
  logic              peek_direct;
  logic              peek_now;
  logic [ADDR_W-1:0] pos_now;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_raddr;
  logic [BYTE_W-1:0] ram_rdata;
  logic              mod_start;
  logic              mod_done;
  logic [ADDR_W-1:0] mod_rem;

  // advance a position by one, wrap at the capacity
  function automatic logic [ADDR_W-1:0] wrap_inc(input logic [ADDR_W-1:0] p,
                                                 input logic [CNT_W-1:0]  cap);
    logic [CNT_W-1:0] nxt;
    nxt = CNT_W'(p) + CNT_W'(1);
    return (nxt >= cap) ? '0 : nxt[ADDR_W-1:0];
  endfunction

  // clamp the register value: zero acts as one, above the depth acts as depth
  function automatic logic [CNT_W-1:0] cap_eff(input logic [CNT_W-1:0] v);
    if (v == '0) begin
      return CNT_W'(1);
    end else if (v > CNT_W'(DEPTH)) begin
      return CNT_W'(DEPTH);
    end else begin
      return v;
    end
  endfunction

  // one item at a time: the FSM is the interlock on the byte store
  assign req_stall = (state != S_IDLE);
  assign cfg_ready = (state == S_IDLE) && !req_valid;
  assign accept    = req_valid && (state == S_IDLE);

  assign full  = (fill == capacity);
  assign empty = (fill == '0);

  assign ppos_in_range = (CNT_W'(req.peek_pos) < capacity);
  assign peek_direct   = accept && (req.func == FUNC_PEEK) && (req.use_head || ppos_in_range);
  assign peek_now      = peek_direct || ((state == S_MOD) && mod_done);
  assign pos_now       = (state == S_MOD) ? mod_rem :
                         (req.use_head ? head : req.peek_pos);

  assign mod_start = accept && (req.func == FUNC_PEEK) && !req.use_head && !ppos_in_range;

  // pop reads at head, peek at the resolved position
  assign ram_raddr = (accept && (req.func == FUNC_POP)) ? head : pos_now;
  assign ram_we    = accept && (req.func == FUNC_WRITE) && !full;

  brbp_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (tail),
    .wdata (req.byte_in),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  brbp_mod u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (mod_start),
    .dividend (req.peek_pos),
    .divisor  (capacity),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      tail      <= '0;
      fill      <= '0;
      capacity  <= CNT_W'(DEPTH);
      rsp_valid <= 1'b0;
    end else begin
      // drop the result once taken, unless a new one replaces it
      if (rsp_valid && !rsp_stall && (state != S_FIN)) begin
        rsp_valid <= 1'b0;
      end

      // a capacity write empties the FIFO, stored bytes stay
      if (cfg_valid && cfg_ready) begin
        capacity <= cap_eff(cfg_data);
        head     <= '0;
        tail     <= '0;
        fill     <= '0;
      end

      // peek with a resolved position: read if anything is stored
      if (peek_now) begin
        if (!empty) begin
          res_ok  <= 1'b1;
          res_npp <= wrap_inc(pos_now, capacity);
          state   <= S_RDATA;
        end else begin
          res_ok   <= 1'b0;
          res_byte <= '0;
          res_npp  <= pos_now;
          state    <= S_FIN;
        end
      end

      case (state)
        S_IDLE: begin
          if (req_valid) begin
            res_last <= req.last_byte;
            case (req.func)
              FUNC_WRITE: begin
                res_byte <= '0;
                res_npp  <= '0;
                res_ok   <= !full;
                if (!full) begin
                  tail <= wrap_inc(tail, capacity);
                  fill <= fill + CNT_W'(1);
                end
                state <= S_FIN;
              end
              FUNC_POP: begin
                res_npp <= '0;
                if (!empty) begin
                  res_ok <= 1'b1;
                  head   <= wrap_inc(head, capacity);
                  fill   <= fill - CNT_W'(1);
                  state  <= S_RDATA;
                end else begin
                  res_ok   <= 1'b0;
                  res_byte <= '0;
                  state    <= S_FIN;
                end
              end
              FUNC_PEEK: begin
                // head and in-range peeks are handled above; reduce the rest first
                if (mod_start) begin
                  state <= S_MOD;
                end
              end
              default: begin
                res_ok   <= 1'b0;
                res_byte <= '0;
                res_npp  <= '0;
                state    <= S_FIN;
              end
            endcase
          end
        end
        S_MOD: begin
          // hold until the remainder unit reports, handled by peek_now
        end
        S_RDATA: begin
          res_byte <= ram_rdata;
          state    <= S_FIN;
        end
        S_FIN: begin
          // load the result register once it is free or being taken
          if (!rsp_valid || !rsp_stall) begin
            rsp.byte_out      <= res_byte;
            rsp.ok            <= res_ok;
            rsp.fill_level    <= fill;
            rsp.free_space    <= capacity - fill;
            rsp.next_peek_pos <= res_npp;
            rsp.last_out      <= res_last;
            rsp_valid         <= 1'b1;
            state             <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    (fill <= capacity) && (capacity != '0))
    else $error("fill above capacity");
  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    (CNT_W'(head) < capacity) && (CNT_W'(tail) < capacity))
    else $error("head or tail outside the capacity");
  a_ptr_fill: assert property (@(posedge clk) disable iff (rst)
    (head == tail) == (empty || full))
    else $error("head and tail disagree with fill");
  a_mod_state: assert property (@(posedge clk) disable iff (rst)
    mod_done |-> (state == S_MOD))
    else $error("remainder done outside the reduce state");
  a_rdata_src: assert property (@(posedge clk) disable iff (rst)
    (state == S_RDATA) |-> ($past(state) == S_IDLE || $past(state) == S_MOD))
    else $error("read data state entered from the wrong state");

endmodule

`default_nettype wire

// ===== tb/sv/byte_ring_buffer_with_peek_unit_tb.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// byte_ring_buffer_with_peek_unit_tb: self-checking bench of the byte FIFO
// Drives write, pop, peek and idle items under random gaps and stalls, runs
// several capacities, and checks every result against a bit-exact predictor.
// ---------------------------------------------------------------------------

module byte_ring_buffer_with_peek_unit_tb;
  import brbp_pkg::*;

  // func code 3 has no operation behind it
  localparam logic [FUNC_W-1:0] FUNC_NONE = 2'd3;

  // Capacities of the random phases: extremes, out-of-range values, odd sizes.
  localparam logic [CNT_W-1:0] CAP_PLAN [10] =
    '{11'd2047, 11'd2, 11'd5, 11'd1025, 11'd16, 11'd300, 11'd3, 11'd1024, 11'd64, 11'd1};

  // -------------------------------------------------------------------------
  // FIFO predictor and result checker. It mirrors the store, head, tail, fill
  // and capacity register, and queues one expected result per accepted item.
  // -------------------------------------------------------------------------
  class ring_scoreboard;
    logic [BYTE_W-1:0] store [DEPTH];
    bit                written [DEPTH];
    logic [ADDR_W-1:0] head_pos;
    logic [ADDR_W-1:0] tail_pos;
    logic [CNT_W-1:0]  fill_count;
    logic [CNT_W-1:0]  cap_reg;
    rsp_t              expected_results [$];
    rsp_t              last_prediction;
    int                mismatch_count;

    function new();
      head_pos       = '0;
      tail_pos       = '0;
      fill_count     = '0;
      cap_reg        = 11'd1024;
      mismatch_count = 0;
      foreach (written[i]) written[i] = 1'b0;
    endfunction

    // Clamp the register value to 1..DEPTH.
    function int eff_cap();
      if (cap_reg == 0) return 1;
      if (cap_reg > DEPTH) return DEPTH;
      return int'(cap_reg);
    endfunction

    function int next_pos(int p);
      return (p + 1 >= eff_cap()) ? 0 : p + 1;
    endfunction

    // A capacity write also empties the FIFO; stored bytes stay.
    function void set_capacity(logic [CNT_W-1:0] cap_value);
      cap_reg    = cap_value;
      head_pos   = '0;
      tail_pos   = '0;
      fill_count = '0;
    endfunction

    // A peek away from the head must not land on a slot never written.
    function bit peek_is_safe(req_t op_in);
      if (op_in.func != FUNC_PEEK || op_in.use_head || fill_count == 0) return 1'b1;
      return written[int'(op_in.peek_pos) % eff_cap()];
    endfunction

    function void note_accepted_op(req_t op_in);
      rsp_t r;
      int   cap;
      int   pos;
      cap        = eff_cap();
      r          = '0;
      r.last_out = op_in.last_byte;
      case (op_in.func)
        FUNC_WRITE: begin
          if (fill_count < cap) begin
            store[tail_pos]   = op_in.byte_in;
            written[tail_pos] = 1'b1;
            tail_pos          = ADDR_W'(next_pos(int'(tail_pos)));
            fill_count++;
            r.ok = 1'b1;
          end
        end
        FUNC_POP: begin
          if (fill_count != 0) begin
            r.byte_out = store[head_pos];
            head_pos   = ADDR_W'(next_pos(int'(head_pos)));
            fill_count--;
            r.ok = 1'b1;
          end
        end
        FUNC_PEEK: begin
          pos = op_in.use_head ? int'(head_pos) : int'(op_in.peek_pos) % cap;
          if (fill_count != 0) begin
            r.byte_out      = store[pos];
            r.next_peek_pos = ADDR_W'(next_pos(pos));
            r.ok            = 1'b1;
          end else begin
            // refused peek hands back the position unchanged
            r.next_peek_pos = ADDR_W'(pos);
          end
        end
        default: ;
      endcase
      r.fill_level = fill_count;
      r.free_space = CNT_W'(cap - int'(fill_count));
      expected_results.push_back(r);
      last_prediction = r;
    endfunction

    function void compare_field(string name, logic [CNT_W-1:0] want, logic [CNT_W-1:0] got);
      if (got !== want) begin
        $error("%s mismatch: expected %0d, got %0d", name, want, got);
        mismatch_count++;
      end
    endfunction

    function void check_result(rsp_t got);
      rsp_t want;
      if (expected_results.size() == 0) begin
        $error("result with no item outstanding: %p", got);
        mismatch_count++;
        return;
      end
      want = expected_results.pop_front();
      compare_field("byte_out", CNT_W'(want.byte_out), CNT_W'(got.byte_out));
      compare_field("ok", CNT_W'(want.ok), CNT_W'(got.ok));
      compare_field("fill_level", want.fill_level, got.fill_level);
      compare_field("free_space", want.free_space, got.free_space);
      compare_field("next_peek_pos", CNT_W'(want.next_peek_pos),
                    CNT_W'(got.next_peek_pos));
      compare_field("last_out", CNT_W'(want.last_out), CNT_W'(got.last_out));
    endfunction

    function int pending();
      return expected_results.size();
    endfunction
  endclass

  logic             clk;
  logic             rst;
  logic             req_valid;
  logic             req_stall;
  req_t             req;
  logic             rsp_valid;
  logic             rsp_stall;
  rsp_t             rsp;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [CNT_W-1:0] cfg_data;

  ring_scoreboard sb = new();

  // Shared pacing knobs: no_idle drops all gaps on both sides, burst_left
  // counts sender items still sent back to back, rx_hold_cycles asks the
  // receiver for one long stall.
  bit no_idle        = 1'b0;
  int burst_left     = 0;
  int rx_hold_cycles = 0;

  byte_ring_buffer_with_peek_unit dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Check every result item at the edge that accepts it.
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      sb.check_result(rsp);
    end
  end

  // Result side: draw a stall length per item, or take the long hold-off
  // when one is asked for, then release and wait for the item to go.
  initial begin
    int n;
    rsp_stall = 1'b0;
    forever begin
      if (rx_hold_cycles > 0) begin
        n              = rx_hold_cycles;
        rx_hold_cycles = 0;
      end else if (no_idle) begin
        n = 0;
      end else begin
        n = $urandom_range(0, 11);
      end
      repeat (n) begin
        @(negedge clk);
        rsp_stall <= 1'b1;
      end
      @(negedge clk);
      rsp_stall <= 1'b0;
      do @(posedge clk); while (!(rsp_valid && !rsp_stall));
    end
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #10_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  function req_t make_op(logic [FUNC_W-1:0] f, logic [BYTE_W-1:0] b, logic uh,
                         logic [ADDR_W-1:0] pp, logic lst);
    req_t it;
    it.func      = f;
    it.byte_in   = b;
    it.use_head  = uh;
    it.peek_pos  = pp;
    it.last_byte = lst;
    return it;
  endfunction

  // Offer one item after a random gap, hold it until accepted, then note it.
  // The next call (or drain_results) replaces or drops valid at the next
  // falling edge, so no item is offered twice.
  task send_item(input req_t it);
    int gap;
    gap = (no_idle || burst_left > 0) ? 0 : $urandom_range(0, 11);
    if (burst_left > 0) burst_left--;
    repeat (gap) begin
      @(negedge clk);
      req_valid <= 1'b0;
    end
    @(negedge clk);
    req       <= it;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
    sb.note_accepted_op(it);
  endtask

  // Drop valid and wait until every expected result item has come back.
  task drain_results();
    @(negedge clk);
    req_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Write the capacity register only once the unit has gone idle.
  task write_capacity(input logic [CNT_W-1:0] cap_value);
    drain_results();
    @(negedge clk);
    cfg_data  <= cap_value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    sb.set_capacity(cap_value);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Random traffic built as runs: write bursts, pop bursts, peek walks that
  // follow the returned position, and a share of fully random noise items.
  task run_random_phase(input int item_goal);
    req_t it;
    int   kind;
    int   run_len;
    int   done;
    int   hop_room;
    done = 0;
    while (done < item_goal) begin
      kind    = $urandom_range(0, 9);
      run_len = $urandom_range(1, 12);
      for (int k = 0; k < run_len && done < item_goal; k++) begin
        it.byte_in   = BYTE_W'($urandom_range(0, 255));
        it.use_head  = 1'($urandom_range(0, 1));
        it.peek_pos  = ADDR_W'($urandom_range(0, DEPTH - 1));
        it.last_byte = (k == run_len - 1);
        if (kind <= 4) begin
          it.func = FUNC_WRITE;
        end else if (kind <= 6) begin
          it.func = FUNC_POP;
        end else if (kind <= 8) begin
          it.func = FUNC_PEEK;
          if (k > 0) begin
            // step on from the position the last peek handed back, and now
            // and then add whole capacities to go through the modulo path
            it.use_head = 1'b0;
            it.peek_pos = sb.last_prediction.next_peek_pos;
            hop_room    = (DEPTH - 1 - it.peek_pos) / sb.eff_cap();
            if (hop_room > 0 && $urandom_range(0, 3) == 0) begin
              it.peek_pos = ADDR_W'(it.peek_pos +
                                    sb.eff_cap() * $urandom_range(1, hop_room));
            end
          end
        end else begin
          it.func      = FUNC_W'($urandom_range(0, 3));
          it.last_byte = 1'($urandom_range(0, 1));
        end
        // fall back to the head rather than peek a slot never written
        if (!sb.peek_is_safe(it)) it.use_head = 1'b1;
        send_item(it);
        if (it.func != FUNC_NONE) done++;
      end
    end
  endtask

  initial begin
    rst       = 1'b1;
    req_valid = 1'b0;
    req       = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part at the reset capacity: refusals while empty, the idle
    // code with every bit set, a short run written, peeked and popped.
    send_item(make_op(FUNC_POP, 8'h00, 1'b0, 10'd0, 1'b1));
    send_item(make_op(FUNC_PEEK, 8'h00, 1'b1, 10'd0, 1'b0));
    send_item(make_op(FUNC_PEEK, 8'h00, 1'b0, 10'd1023, 1'b1));
    send_item(make_op(FUNC_NONE, 8'hFF, 1'b1, 10'd1023, 1'b1));
    send_item(make_op(FUNC_WRITE, 8'h00, 1'b0, 10'd0, 1'b0));
    send_item(make_op(FUNC_WRITE, 8'hFF, 1'b1, 10'd1023, 1'b0));
    send_item(make_op(FUNC_WRITE, 8'hA5, 1'b0, 10'd0, 1'b0));
    send_item(make_op(FUNC_WRITE, 8'h5A, 1'b0, 10'd0, 1'b1));
    send_item(make_op(FUNC_PEEK, 8'h00, 1'b1, 10'd0, 1'b0));
    send_item(make_op(FUNC_PEEK, 8'h00, 1'b0, 10'd1, 1'b0));
    send_item(make_op(FUNC_PEEK, 8'h00, 1'b0, 10'd3, 1'b1));
    send_item(make_op(FUNC_POP, 8'h00, 1'b0, 10'd0, 1'b0));
    send_item(make_op(FUNC_POP, 8'h00, 1'b0, 10'd0, 1'b0));
    send_item(make_op(FUNC_POP, 8'h00, 1'b0, 10'd0, 1'b0));
    send_item(make_op(FUNC_POP, 8'h00, 1'b0, 10'd0, 1'b1));
    send_item(make_op(FUNC_POP, 8'h00, 1'b0, 10'd0, 1'b0));

    // Capacity one: full after a single write, a peek far out of range.
    write_capacity(11'd1);
    send_item(make_op(FUNC_WRITE, 8'h77, 1'b0, 10'd0, 1'b0));
    send_item(make_op(FUNC_WRITE, 8'h88, 1'b0, 10'd0, 1'b1));
    send_item(make_op(FUNC_PEEK, 8'h00, 1'b0, 10'd1023, 1'b0));
    send_item(make_op(FUNC_PEEK, 8'h00, 1'b1, 10'd0, 1'b0));
    send_item(make_op(FUNC_POP, 8'h00, 1'b0, 10'd0, 1'b1));
    send_item(make_op(FUNC_POP, 8'h00, 1'b0, 10'd0, 1'b0));

    // A register value of zero behaves as capacity one.
    write_capacity(11'd0);
    send_item(make_op(FUNC_WRITE, 8'h3C, 1'b0, 10'd0, 1'b0));
    send_item(make_op(FUNC_WRITE, 8'hC3, 1'b0, 10'd0, 1'b0));
    send_item(make_op(FUNC_POP, 8'h00, 1'b0, 10'd0, 1'b1));

    // Random phases, one per capacity. Phases 2 and 7 run with no gaps at
    // all; phase 4 stalls the result side for a long stretch while items
    // keep coming back to back; phase 6 pauses until the unit drains.
    for (int p = 0; p < 10; p++) begin
      write_capacity(CAP_PLAN[p]);
      no_idle = (p == 2 || p == 7);
      if (p == 4) begin
        rx_hold_cycles = 60;
        burst_left     = 30;
      end
      if (p == 6) begin
        run_random_phase(42);
        drain_results();
        run_random_phase(43);
      end else begin
        run_random_phase(85);
      end
    end

    drain_results();
    repeat (30) @(posedge clk);
    if (sb.mismatch_count == 0 && sb.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
